// ===== src/nfba_pkg.sv =====
package nfba_pkg;

    localparam int OFF_W = 10;
    localparam int DEPTH = 1024;

    typedef logic [OFF_W-1:0] off_t;

    typedef enum logic [1:0] {
        MODE_ALLOC    = 2'd0,
        MODE_RELEASE  = 2'd1,
        MODE_COALESCE = 2'd2,
        MODE_NONE     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        LW_NONE,
        LW_ABSORB,
        LW_SPLIT_NEW,
        LW_SPLIT_HEAD
    } lnk_wr_t;

    typedef enum logic [1:0] {
        UW_NONE,
        UW_RELEASE,
        UW_SPLIT_NEW,
        UW_MARK
    } used_wr_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_ZERO,
        RES_FAIL,
        RES_GRANT
    } res_t;

    typedef struct packed {
        logic     start_alloc;
        logic     start_coal;
        logic     addr_nxt;
        logic     load_nxt;
        logic     advance;
        logic     next_blk;
        logic     cursor_zero;
        lnk_wr_t  lnk_wr;
        used_wr_t used_wr;
        res_t     res;
        logic     out_load;
    } nfba_cmd_t;

    typedef struct packed {
        logic too_big;
        logic rd_used;
        logic rd_link_tail;
        logic wrap_hit;
        logic first;
        logic nxt_tail;
        logic fits;
        logic do_split;
    } nfba_sts_t;

endpackage

// ===== src/next_fit_block_allocator.sv =====
// Channel  Handshake            Fields
// in       in_valid/in_ready    mode, request_size, block_offset
// out      out_valid/out_ready  payload_offset, status
//
// One item at a time. Release and oversized requests go from idle through the done
// state to the output register. Allocate walks blocks from the cursor, skipping used
// blocks and merging each free block with the free blocks that follow it; a fitting
// block is split if room remains, then marked, and the grant goes into the output
// register.
// Coalesce walks every block from offset 0, merging the free blocks that follow it.
// Reset leaves one free block spanning the pool; no clearing pass.
// A result waiting on out_ready does not block acceptance of the next item.
module next_fit_block_allocator
    import nfba_pkg::*;
#(
    parameter int POOL_BYTES   = 512,
    parameter int HEADER_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [9:0]  request_size,
    input  logic [9:0]  block_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  payload_offset,
    output logic        status
);

    nfba_cmd_t cmd;
    nfba_sts_t sts;

    nfba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    nfba_datapath #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .request_size   (request_size),
        .block_offset   (block_offset),
        .cmd            (cmd),
        .sts            (sts),
        .payload_offset (payload_offset),
        .status         (status)
    );

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> payload_offset == '0)
        else $error("failed item carries nonzero offset");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    a_grant_past_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status && payload_offset != '0
            |-> payload_offset >= 10'(HEADER_BYTES))
        else $error("grant below header size");

endmodule

// ===== src/nfba_datapath.sv =====
module nfba_datapath
    import nfba_pkg::*;
#(
    parameter int POOL_BYTES   = 512,
    parameter int HEADER_BYTES = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [OFF_W-1:0]        request_size,
    input  logic [OFF_W-1:0]        block_offset,
    input  nfba_cmd_t               cmd,
    output nfba_sts_t               sts,
    output logic [OFF_W-1:0]        payload_offset,
    output logic                    status
);

    localparam off_t TAIL   = off_t'((HEADER_BYTES + POOL_BYTES) % DEPTH);
    localparam off_t HDR    = off_t'(HEADER_BYTES);
    localparam logic [OFF_W:0] HDR_W = (OFF_W+1)'(HEADER_BYTES);
    localparam logic [OFF_W:0] POOL_W = (OFF_W+1)'(POOL_BYTES);

    off_t link_mem [DEPTH];
    logic used_mem [DEPTH];

    off_t cursor_reg, cursor_next;
    off_t blk_reg, blk_next;
    off_t nxt_reg, nxt_next;
    off_t anchor_reg, anchor_next;
    logic first_reg, first_next;
    off_t size_reg, size_next;
    off_t res_off_reg, res_off_next;
    logic res_fail_reg, res_fail_next;
    off_t out_off_reg, out_off_next;
    logic out_fail_reg, out_fail_next;
    off_t link0_reg, link0_next;
    logic used0_reg, used0_next;
    off_t rd_link_reg;
    logic rd_used_reg;

    off_t             rd_addr;
    logic [OFF_W:0]   blk_h;
    logic [OFF_W:0]   size_h;
    logic [OFF_W:0]   cap;
    off_t             sep;
    off_t             ncur;
    off_t             rel_addr;
    logic             lnk_we;
    off_t             lnk_waddr;
    off_t             lnk_wdata;
    logic             used_we;
    off_t             used_waddr;
    logic             used_wdata;

    always_comb
    begin
        rd_addr  = cmd.addr_nxt ? nxt_reg : blk_reg;
        blk_h    = {1'b0, blk_reg} + HDR_W;
        size_h   = {1'b0, size_reg} + HDR_W;
        cap      = ({1'b0, nxt_reg} > blk_h) ? ({1'b0, nxt_reg} - blk_h) : '0;
        sep      = off_t'(blk_h + {1'b0, size_reg});
        ncur     = (nxt_reg == TAIL) ? '0 : nxt_reg;
        rel_addr = block_offset - HDR;

        sts.too_big      = {1'b0, request_size} > POOL_W;
        sts.rd_used      = rd_used_reg;
        sts.rd_link_tail = rd_link_reg == TAIL;
        sts.wrap_hit     = (blk_reg <= anchor_reg) && (anchor_reg < rd_link_reg);
        sts.first        = first_reg;
        sts.nxt_tail     = nxt_reg == TAIL;
        sts.fits         = {1'b0, size_reg} <= cap;
        sts.do_split     = cap > size_h;

        lnk_we    = 1'b1;
        lnk_waddr = blk_reg;
        lnk_wdata = rd_link_reg;
        case (cmd.lnk_wr)
            LW_ABSORB:
            begin
                lnk_waddr = blk_reg;
                lnk_wdata = rd_link_reg;
            end
            LW_SPLIT_NEW:
            begin
                lnk_waddr = sep;
                lnk_wdata = nxt_reg;
            end
            LW_SPLIT_HEAD:
            begin
                lnk_waddr = blk_reg;
                lnk_wdata = sep;
            end
            default:
            begin
                lnk_we = 1'b0;
            end
        endcase

        used_we    = 1'b1;
        used_waddr = blk_reg;
        used_wdata = 1'b0;
        case (cmd.used_wr)
            UW_RELEASE:
            begin
                used_waddr = rel_addr;
                used_wdata = 1'b0;
            end
            UW_SPLIT_NEW:
            begin
                used_waddr = sep;
                used_wdata = 1'b0;
            end
            UW_MARK:
            begin
                used_waddr = blk_reg;
                used_wdata = 1'b1;
            end
            default:
            begin
                used_we = 1'b0;
            end
        endcase

        cursor_next   = cursor_reg;
        blk_next      = blk_reg;
        nxt_next      = nxt_reg;
        anchor_next   = anchor_reg;
        first_next    = first_reg;
        size_next     = size_reg;
        res_off_next  = res_off_reg;
        res_fail_next = res_fail_reg;
        out_off_next  = out_off_reg;
        out_fail_next = out_fail_reg;
        link0_next    = link0_reg;
        used0_next    = used0_reg;

        if (cmd.start_alloc)
        begin
            blk_next    = cursor_reg;
            anchor_next = cursor_reg;
            first_next  = 1'b1;
            size_next   = request_size;
        end
        if (cmd.start_coal)
        begin
            blk_next = '0;
        end
        if (cmd.load_nxt)
        begin
            nxt_next = rd_link_reg;
        end
        if (cmd.advance)
        begin
            blk_next    = ncur;
            cursor_next = ncur;
            first_next  = 1'b0;
        end
        if (cmd.next_blk)
        begin
            blk_next = nxt_reg;
        end
        if (cmd.cursor_zero)
        begin
            cursor_next = '0;
        end
        case (cmd.res)
            RES_ZERO:
            begin
                res_off_next  = '0;
                res_fail_next = 1'b0;
            end
            RES_FAIL:
            begin
                res_off_next  = '0;
                res_fail_next = 1'b1;
            end
            RES_GRANT:
            begin
                res_off_next  = off_t'(blk_h);
                res_fail_next = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (cmd.out_load)
        begin
            out_off_next  = res_off_reg;
            out_fail_next = res_fail_reg;
        end
        if (lnk_we && lnk_waddr == '0)
        begin
            link0_next = lnk_wdata;
        end
        if (used_we && used_waddr == '0)
        begin
            used0_next = used_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= '0;
            blk_reg      <= '0;
            nxt_reg      <= '0;
            anchor_reg   <= '0;
            first_reg    <= 1'b0;
            size_reg     <= '0;
            res_off_reg  <= '0;
            res_fail_reg <= 1'b0;
            out_off_reg  <= '0;
            out_fail_reg <= 1'b0;
            link0_reg    <= TAIL;
            used0_reg    <= 1'b0;
        end
        else
        begin
            cursor_reg   <= cursor_next;
            blk_reg      <= blk_next;
            nxt_reg      <= nxt_next;
            anchor_reg   <= anchor_next;
            first_reg    <= first_next;
            size_reg     <= size_next;
            res_off_reg  <= res_off_next;
            res_fail_reg <= res_fail_next;
            out_off_reg  <= out_off_next;
            out_fail_reg <= out_fail_next;
            link0_reg    <= link0_next;
            used0_reg    <= used0_next;
        end
    end

    // entry 0 lives in flops so the head is valid out of reset
    always_ff @(posedge clk)
    begin
        if (lnk_we && lnk_waddr != '0)
        begin
            link_mem[lnk_waddr] <= lnk_wdata;
        end
        if (used_we && used_waddr != '0)
        begin
            used_mem[used_waddr] <= used_wdata;
        end
        rd_link_reg <= (rd_addr == '0) ? link0_reg : link_mem[rd_addr];
        rd_used_reg <= (rd_addr == '0) ? used0_reg : used_mem[rd_addr];
    end

    assign payload_offset = out_off_reg;
    assign status         = out_fail_reg;

endmodule

// ===== src/nfba_ctrl.sv =====
module nfba_ctrl
    import nfba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    output logic        out_valid,
    input  logic        out_ready,
    input  nfba_sts_t   sts,
    output nfba_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_ABS_RD,
        S_ABS_EVAL,
        S_POST,
        S_ADV,
        S_SPLIT,
        S_MARK,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   coal_reg, coal_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        cmd.lnk_wr = LW_NONE;
        cmd.used_wr = UW_NONE;
        cmd.res    = RES_NONE;
        state_next = state_reg;
        coal_next  = coal_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.res = RES_ZERO;
                    state_next = S_DONE;
                    case (mode_t'(mode))
                        MODE_ALLOC:
                        begin
                            if (sts.too_big)
                            begin
                                cmd.res = RES_FAIL;
                            end
                            else
                            begin
                                cmd.start_alloc = 1'b1;
                                coal_next = 1'b0;
                                state_next = S_RD;
                            end
                        end
                        MODE_RELEASE:
                        begin
                            cmd.used_wr = UW_RELEASE;
                        end
                        MODE_COALESCE:
                        begin
                            cmd.start_coal = 1'b1;
                            coal_next = 1'b1;
                            state_next = S_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (coal_reg)
                begin
                    cmd.load_nxt = 1'b1;
                    if (sts.rd_link_tail)
                    begin
                        cmd.cursor_zero = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ABS_RD;
                    end
                end
                else if (!sts.first && sts.wrap_hit)
                begin
                    cmd.res = RES_FAIL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.load_nxt = 1'b1;
                    if (sts.rd_used)
                    begin
                        state_next = S_ADV;
                    end
                    else if (sts.rd_link_tail)
                    begin
                        state_next = S_POST;
                    end
                    else
                    begin
                        state_next = S_ABS_RD;
                    end
                end
            end
            S_ABS_RD:
            begin
                cmd.addr_nxt = 1'b1;
                state_next = S_ABS_EVAL;
            end
            S_ABS_EVAL:
            begin
                if (sts.rd_used)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    cmd.lnk_wr = LW_ABSORB;
                    cmd.load_nxt = 1'b1;
                    state_next = sts.rd_link_tail ? S_POST : S_ABS_RD;
                end
            end
            S_POST:
            begin
                if (coal_reg)
                begin
                    if (sts.nxt_tail)
                    begin
                        cmd.cursor_zero = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.next_blk = 1'b1;
                        state_next = S_RD;
                    end
                end
                else if (sts.fits)
                begin
                    state_next = sts.do_split ? S_SPLIT : S_MARK;
                end
                else
                begin
                    state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                state_next = S_RD;
            end
            S_SPLIT:
            begin
                cmd.lnk_wr = LW_SPLIT_NEW;
                cmd.used_wr = UW_SPLIT_NEW;
                state_next = S_MARK;
            end
            S_MARK:
            begin
                if (sts.do_split)
                begin
                    cmd.lnk_wr = LW_SPLIT_HEAD;
                end
                cmd.used_wr = UW_MARK;
                cmd.res = RES_GRANT;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = cmd.out_load | (out_valid_reg & ~out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            coal_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            coal_reg      <= coal_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule
